// ----- sv/mmda_pkg.sv -----
package mmda_pkg;

  // Default store sizes.
  localparam int unsigned MAX_JOBS_DEF     = 64;
  localparam int unsigned MAX_MACHINES_DEF = 16;

  // Function codes of a request beat.
  localparam logic [1:0] FUNC_LOAD_JOB  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_MACH = 2'd1;
  localparam logic [1:0] FUNC_RUN       = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] proc_time;
    logic [31:0] due_time;
    logic [15:0] job_tag;
    logic [31:0] avail_time;
    logic [7:0]  machine_id;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_machine;
    logic [15:0] out_job;
    logic        assigned;
    logic        last;
  } rsp_t;

  // One entry of the job memory.
  typedef struct packed {
    logic [31:0] proc_time;
    logic [31:0] due_time;
    logic [15:0] job_tag;
  } job_t;

  // One entry of the machine memory.
  typedef struct packed {
    logic [31:0] avail_time;
    logic [7:0]  machine_id;
  } mach_t;

endpackage

// ----- sv/mmda_ram.sv -----
module mmda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/multi_machine_deadline_assigner.sv -----
// Multi-machine deadline assigner.
// Request channel (req_valid/req_ready/req): a beat loads one job, loads one
// machine, or starts a run. Load beats are taken one per cycle while idle; a
// job load beyond MAX_JOBS or a machine load beyond MAX_MACHINES is dropped.
// A run sorts the machines by availability and, for each one, runs
// Moore-Hodgson over the jobs still open, starting at that availability. The
// earliest-deadline on-time job goes to the machine. One response beat
// (rsp_valid/rsp_ready/rsp) follows per machine, the final one with last set.
// Every pass walks one memory one entry per cycle through its single read
// port. Per machine: one pass over the M machines to find the next one, then
// one pass over the J loaded jobs per open job taken in deadline order, one
// more per late job, one that finds nothing left and one to pick; the result
// is then held in the response register. After the last response (at once
// when no machine is loaded) a compaction pass removes assigned jobs; the rest
// stay loaded in load order and the machine list is emptied. No request is
// taken while a run is in progress. A stalled response is held in its register
// and the run waits until it is taken. Reset empties both stores; no clearing
// pass is needed.
module multi_machine_deadline_assigner #(
  parameter int unsigned MAX_JOBS     = mmda_pkg::MAX_JOBS_DEF,
  parameter int unsigned MAX_MACHINES = mmda_pkg::MAX_MACHINES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mmda_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mmda_pkg::rsp_t rsp
);

  localparam int unsigned IW  = $clog2(MAX_JOBS);
  localparam int unsigned MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned JCW = $clog2(MAX_JOBS + 1);
  localparam int unsigned MCW = $clog2(MAX_MACHINES + 1);
  localparam int unsigned SW  = (JCW > MCW) ? JCW : MCW;
  localparam int unsigned RW  = 32 + JCW;
  localparam int unsigned JBW = $bits(mmda_pkg::job_t);
  localparam int unsigned MBW = $bits(mmda_pkg::mach_t);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MSCAN = 7'b0000010,
    S_JSCAN = 7'b0000100,
    S_DROP  = 7'b0001000,
    S_PICK  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_CPY   = 7'b1000000
  } state_t;

  state_t state;

  logic [JCW-1:0] job_count;
  logic [MCW-1:0] machine_count;
  logic [MCW-1:0] m_step;
  logic [JCW-1:0] kept;
  logic [RW-1:0]  running;
  logic [MAX_JOBS-1:0] remaining;
  logic [MAX_JOBS-1:0] on_time;

  // Scan engine: issue counter and the index whose data is arriving.
  logic [SW-1:0] scan_i;
  logic [SW-1:0] pidx;
  logic          pend;
  logic [SW-1:0] lim;
  logic          scan_done;

  // Best candidate of the current job scan.
  logic          best_v;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_proc;
  logic [31:0]   best_due;
  logic [15:0]   best_tag;

  // Last job taken in deadline order.
  logic          prev_v;
  logic [IW-1:0] prev_idx;
  logic [31:0]   prev_due;

  // Machine selection.
  logic          mb_v;
  logic [MW-1:0] mb_idx;
  logic [31:0]   mb_avail;
  logic [7:0]    mb_id;
  logic          mprev_v;
  logic [MW-1:0] mprev_idx;
  logic [31:0]   mprev_avail;

  // Memory ports.
  logic            job_we;
  logic [IW-1:0]   job_waddr;
  logic [JBW-1:0]  job_wdata;
  logic [JBW-1:0]  job_rdata;
  logic            mach_we;
  logic [MBW-1:0]  mach_rdata;
  mmda_pkg::job_t  jd;
  mmda_pkg::mach_t md;
  mmda_pkg::job_t  new_job;
  mmda_pkg::mach_t new_mach;

  logic            req_fire;
  logic [IW-1:0]   pi;
  logic [MW-1:0]   pm;
  logic [RW-1:0]   sum;
  logic            job_after_prev;
  logic            mach_after_prev;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_valid = (state == S_EMIT);

  assign jd = mmda_pkg::job_t'(job_rdata);
  assign md = mmda_pkg::mach_t'(mach_rdata);
  assign pi = pidx[IW-1:0];
  assign pm = pidx[MW-1:0];

  assign new_job.proc_time  = req.proc_time;
  assign new_job.due_time   = req.due_time;
  assign new_job.job_tag    = req.job_tag;
  assign new_mach.avail_time = req.avail_time;
  assign new_mach.machine_id = req.machine_id;

  // Scan limit and completion.
  assign lim = (state == S_MSCAN) ? SW'(machine_count) : SW'(job_count);
  assign scan_done = (scan_i == lim) && !pend;

  // Key ordering against the previous pick (deadline, then load order).
  assign job_after_prev = !prev_v || (jd.due_time > prev_due) ||
                          ((jd.due_time == prev_due) && (pi > prev_idx));
  assign mach_after_prev = !mprev_v || (md.avail_time > mprev_avail) ||
                           ((md.avail_time == mprev_avail) && (pm > mprev_idx));

  assign sum = running + RW'(best_proc);

  // Job memory writes: loads while idle, compaction during a run.
  always_comb begin
    if (state == S_CPY) begin
      job_we    = pend && remaining[pi];
      job_waddr = kept[IW-1:0];
      job_wdata = job_rdata;
    end else begin
      job_we    = req_fire && (req.func == mmda_pkg::FUNC_LOAD_JOB) &&
                  (job_count < JCW'(MAX_JOBS));
      job_waddr = job_count[IW-1:0];
      job_wdata = JBW'(new_job);
    end
  end

  assign mach_we = req_fire && (req.func == mmda_pkg::FUNC_LOAD_MACH) &&
                   (machine_count < MCW'(MAX_MACHINES));

  mmda_ram #(.WIDTH(JBW), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_waddr),
    .wdata (job_wdata),
    .raddr (scan_i[IW-1:0]),
    .rdata (job_rdata)
  );

  mmda_ram #(.WIDTH(MBW), .DEPTH(MAX_MACHINES)) u_mach_ram (
    .clk   (clk),
    .we    (mach_we),
    .waddr (machine_count[MW-1:0]),
    .wdata (MBW'(new_mach)),
    .raddr (scan_i[MW-1:0]),
    .rdata (mach_rdata)
  );

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      job_count     <= '0;
      machine_count <= '0;
      m_step        <= '0;
      kept          <= '0;
      running       <= '0;
      remaining     <= '0;
      on_time       <= '0;
      scan_i        <= '0;
      pend          <= 1'b0;
      best_v        <= 1'b0;
      prev_v        <= 1'b0;
      mb_v          <= 1'b0;
      mprev_v       <= 1'b0;
    end else begin
      // Issue side of a scan; restarted below on completion.
      if (state != S_IDLE && state != S_EMIT) begin
        if (scan_i != lim) begin
          scan_i <= scan_i + SW'(1);
          pidx   <= scan_i;
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            unique case (req.func)
              mmda_pkg::FUNC_LOAD_JOB: begin
                if (job_count < JCW'(MAX_JOBS)) begin
                  remaining[job_count[IW-1:0]] <= 1'b1;
                  job_count <= job_count + JCW'(1);
                end
              end
              mmda_pkg::FUNC_LOAD_MACH: begin
                if (machine_count < MCW'(MAX_MACHINES)) begin
                  machine_count <= machine_count + MCW'(1);
                end
              end
              mmda_pkg::FUNC_RUN: begin
                m_step  <= '0;
                mprev_v <= 1'b0;
                mb_v    <= 1'b0;
                kept    <= '0;
                scan_i  <= '0;
                pend    <= 1'b0;
                state   <= (machine_count == '0) ? S_CPY : S_MSCAN;
              end
              default: begin
              end
            endcase
          end
        end

        S_MSCAN: begin
          if (scan_done) begin
            mprev_v     <= 1'b1;
            mprev_idx   <= mb_idx;
            mprev_avail <= mb_avail;
            running     <= RW'(mb_avail);
            on_time     <= '0;
            prev_v      <= 1'b0;
            best_v      <= 1'b0;
            scan_i      <= '0;
            pend        <= 1'b0;
            state       <= S_JSCAN;
          end else if (pend && mach_after_prev &&
                       (!mb_v || (md.avail_time < mb_avail))) begin
            mb_v     <= 1'b1;
            mb_idx   <= pm;
            mb_avail <= md.avail_time;
            mb_id    <= md.machine_id;
          end
        end

        S_JSCAN: begin
          if (scan_done) begin
            scan_i <= '0;
            pend   <= 1'b0;
            best_v <= 1'b0;
            if (best_v) begin
              on_time[best_idx] <= 1'b1;
              prev_v   <= 1'b1;
              prev_idx <= best_idx;
              prev_due <= best_due;
              running  <= sum;
              state    <= (sum > RW'(best_due)) ? S_DROP : S_JSCAN;
            end else begin
              state <= S_PICK;
            end
          end else if (pend && remaining[pi] && job_after_prev &&
                       (!best_v || (jd.due_time < best_due))) begin
            best_v    <= 1'b1;
            best_idx  <= pi;
            best_proc <= jd.proc_time;
            best_due  <= jd.due_time;
            best_tag  <= jd.job_tag;
          end
        end

        S_DROP: begin
          if (scan_done) begin
            on_time[best_idx] <= 1'b0;
            running <= running - RW'(best_proc);
            best_v  <= 1'b0;
            scan_i  <= '0;
            pend    <= 1'b0;
            state   <= S_JSCAN;
          end else if (pend && on_time[pi] &&
                       (!best_v || (jd.proc_time > best_proc))) begin
            best_v    <= 1'b1;
            best_idx  <= pi;
            best_proc <= jd.proc_time;
            best_due  <= jd.due_time;
            best_tag  <= jd.job_tag;
          end
        end

        S_PICK: begin
          if (scan_done) begin
            rsp.out_machine <= mb_id;
            rsp.out_job     <= best_v ? best_tag : 16'd0;
            rsp.assigned    <= best_v;
            rsp.last        <= (m_step + MCW'(1) == machine_count);
            if (best_v) begin
              remaining[best_idx] <= 1'b0;
            end
            m_step <= m_step + MCW'(1);
            state  <= S_EMIT;
          end else if (pend && on_time[pi] &&
                       (!best_v || (jd.due_time < best_due))) begin
            best_v    <= 1'b1;
            best_idx  <= pi;
            best_proc <= jd.proc_time;
            best_due  <= jd.due_time;
            best_tag  <= jd.job_tag;
          end
        end

        S_EMIT: begin
          if (rsp_ready) begin
            scan_i <= '0;
            pend   <= 1'b0;
            mb_v   <= 1'b0;
            state  <= rsp.last ? S_CPY : S_MSCAN;
          end
        end

        S_CPY: begin
          if (scan_done) begin
            for (int i = 0; i < MAX_JOBS; i++) begin
              remaining[i] <= (JCW'(i) < kept);
            end
            on_time       <= '0;
            job_count     <= kept;
            machine_count <= '0;
            m_step        <= '0;
            mprev_v       <= 1'b0;
            state         <= S_IDLE;
          end else if (pend && remaining[pi]) begin
            kept <= kept + JCW'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/multi_machine_deadline_assigner_test.sv -----
module multi_machine_deadline_assigner_test;

  localparam int unsigned JOB_SLOTS   = mmda_pkg::MAX_JOBS_DEF;
  localparam int unsigned MACH_SLOTS  = mmda_pkg::MAX_MACHINES_DEF;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned RANDOM_BEATS = 165;
  // Compaction after the last response walks the job memory once more.
  localparam int unsigned SETTLE_CYCLES = 2 * JOB_SLOTS + 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AT_BEAT  = 30;

  typedef struct {
    mmda_pkg::req_t beat;
    bit             typed;
    mmda_pkg::rsp_t result;
  } step_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  mmda_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_ready;
  mmda_pkg::rsp_t rsp;

  // Predictor state: job store, machine list and their counts.
  mmda_pkg::job_t  job_mem [JOB_SLOTS];
  bit              job_open [JOB_SLOTS];
  int              job_total;
  mmda_pkg::mach_t mach_mem [MACH_SLOTS];
  int              mach_total;

  mmda_pkg::rsp_t expected_rsp [$];
  mmda_pkg::rsp_t fresh_rsp [$];
  step_t          directed_steps [$];
  int    errors;
  int    rsp_beats;
  int    cycles;
  bit    send_idle;
  bit    recv_idle;

  multi_machine_deadline_assigner u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Moore-Hodgson over the open jobs from the given start time. Returns the
  // load index of the earliest-deadline on-time job, or -1 if none.
  function automatic int pick_edd_job(logic [31:0] start);
    int          order [JOB_SLOTS];
    bit          on_time [JOB_SLOTS];
    int          n;
    int          j;
    int          idx;
    int          best;
    bit          have;
    logic [63:0] clock_now;
    n = 0;
    for (int i = 0; i < job_total; i++) begin
      on_time[i] = 1'b0;
      if (job_open[i]) begin
        j = n;
        while (j > 0 && job_mem[order[j-1]].due_time > job_mem[i].due_time) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        n++;
      end
    end
    clock_now = {32'd0, start};
    for (int k = 0; k < n; k++) begin
      idx = order[k];
      on_time[idx] = 1'b1;
      clock_now += job_mem[idx].proc_time;
      if (clock_now > {32'd0, job_mem[idx].due_time}) begin
        best = idx;
        have = 1'b0;
        // Strict compare keeps the earliest-loaded job on a tie.
        for (int i = 0; i < job_total; i++) begin
          if (on_time[i] && (!have || job_mem[i].proc_time > job_mem[best].proc_time)) begin
            best = i;
            have = 1'b1;
          end
        end
        on_time[best] = 1'b0;
        clock_now -= job_mem[best].proc_time;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (on_time[order[k]]) return order[k];
    end
    return -1;
  endfunction

  // Apply one accepted request beat to the predictor; results go to fresh_rsp.
  task automatic predict_schedule(mmda_pkg::req_t beat);
    int             order [MACH_SLOTS];
    int             j;
    int             got;
    int             kept;
    mmda_pkg::rsp_t r;
    fresh_rsp.delete();
    case (beat.func)
      mmda_pkg::FUNC_LOAD_JOB: begin
        if (job_total < JOB_SLOTS) begin
          job_mem[job_total] = '{beat.proc_time, beat.due_time, beat.job_tag};
          job_open[job_total] = 1'b1;
          job_total++;
        end
      end
      mmda_pkg::FUNC_LOAD_MACH: begin
        if (mach_total < MACH_SLOTS) begin
          mach_mem[mach_total] = '{beat.avail_time, beat.machine_id};
          mach_total++;
        end
      end
      mmda_pkg::FUNC_RUN: begin
        for (int m = 0; m < mach_total; m++) begin
          j = m;
          while (j > 0 && mach_mem[order[j-1]].avail_time > mach_mem[m].avail_time) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = m;
        end
        for (int m = 0; m < mach_total; m++) begin
          got = pick_edd_job(mach_mem[order[m]].avail_time);
          r.out_machine = mach_mem[order[m]].machine_id;
          r.out_job     = (got >= 0) ? job_mem[got].job_tag : 16'd0;
          r.assigned    = (got >= 0);
          r.last        = (m + 1 == mach_total);
          if (got >= 0) job_open[got] = 1'b0;
          fresh_rsp = {fresh_rsp, r};
        end
        mach_total = 0;
        // Assigned jobs leave; the rest close up in load order.
        kept = 0;
        for (int i = 0; i < job_total; i++) begin
          if (job_open[i]) begin
            job_mem[kept] = job_mem[i];
            job_open[kept] = 1'b1;
            kept++;
          end
        end
        for (int i = kept; i < job_total; i++) job_open[i] = 1'b0;
        job_total = kept;
      end
      default: ;
    endcase
  endtask

  // Offer one request beat, after a random gap when send_idle is set, and wait for it to be taken.
  task automatic offer_beat(mmda_pkg::req_t beat, bit typed, mmda_pkg::rsp_t typed_rsp);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_schedule(beat);
    if (typed) expected_rsp = {expected_rsp, typed_rsp};
    else expected_rsp = {expected_rsp, fresh_rsp};
  endtask

  task automatic send_job(logic [31:0] p, logic [31:0] d, logic [15:0] t);
    mmda_pkg::req_t b;
    b = '0;
    b.func = mmda_pkg::FUNC_LOAD_JOB;
    b.proc_time = p;
    b.due_time = d;
    b.job_tag = t;
    offer_beat(b, 1'b0, '0);
  endtask

  task automatic send_machine(logic [31:0] a, logic [7:0] id);
    mmda_pkg::req_t b;
    b = '0;
    b.func = mmda_pkg::FUNC_LOAD_MACH;
    b.avail_time = a;
    b.machine_id = id;
    offer_beat(b, 1'b0, '0);
  endtask

  task automatic send_run();
    mmda_pkg::req_t b;
    b = '0;
    b.func = mmda_pkg::FUNC_RUN;
    offer_beat(b, 1'b0, '0);
  endtask

  // Hold the sender until every expected beat is back and the block settles.
  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Append one row to the directed table.
  task automatic add_step(step_t st);
    directed_steps = {directed_steps, st};
  endtask

  function automatic step_t job_step(logic [31:0] p, logic [31:0] d, logic [15:0] t);
    step_t s;
    s = '{'0, 1'b0, '0};
    s.beat.func = mmda_pkg::FUNC_LOAD_JOB;
    s.beat.proc_time = p;
    s.beat.due_time = d;
    s.beat.job_tag = t;
    return s;
  endfunction

  function automatic step_t mach_step(logic [31:0] a, logic [7:0] id);
    step_t s;
    s = '{'0, 1'b0, '0};
    s.beat.func = mmda_pkg::FUNC_LOAD_MACH;
    s.beat.avail_time = a;
    s.beat.machine_id = id;
    return s;
  endfunction

  function automatic step_t run_step(bit typed, mmda_pkg::rsp_t r);
    step_t s;
    s = '{'0, typed, r};
    s.beat.func = mmda_pkg::FUNC_RUN;
    return s;
  endfunction

  // Stimulus.
  initial begin
    step_t          s;
    mmda_pkg::req_t b;
    logic [127:0]   raw;
    int     sent;
    int     njobs;
    int     nmach;
    logic [31:0] p;
    logic [31:0] d;
    rst = 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    job_total = 0;
    mach_total = 0;
    send_idle = 1'b0;
    foreach (job_open[i]) job_open[i] = 1'b0;

    // Run with nothing loaded, then a machine with no jobs.
    add_step(run_step(1'b0, '0));
    add_step(mach_step(32'd0, 8'hFF));
    add_step(run_step(1'b1, '{8'hFF, 16'd0, 1'b0, 1'b1}));
    // Unused code with every field set is ignored.
    s = '{'1, 1'b0, '0};
    s.beat.func = FUNC_UNUSED;
    add_step(s);
    add_step(run_step(1'b0, '0));
    // Field extremes; the machine at the top of the time base misses.
    add_step(job_step(32'd0, 32'd0, 16'hFFFF));
    add_step(job_step('1, '1, 16'h0001));
    add_step(mach_step('1, 8'h00));
    add_step(mach_step(32'd0, 8'h12));
    add_step(run_step(1'b0, '0));
    // Equal deadlines and processing times: the earlier load is dropped.
    add_step(job_step(32'd5, 32'd10, 16'h002A));
    add_step(job_step(32'd5, 32'd10, 16'h002B));
    add_step(mach_step(32'd1, 8'h05));
    add_step(run_step(1'b0, '0));
    // Equal availabilities keep load order; late start leaves nothing on time.
    add_step(job_step(32'd3, 32'd20, 16'h0100));
    add_step(job_step(32'd9, 32'd12, 16'h0200));
    add_step(job_step(32'd1, 32'd12, 16'h0300));
    add_step(mach_step(32'd2, 8'h21));
    add_step(mach_step(32'd2, 8'h22));
    add_step(mach_step(32'd100, 8'h23));
    add_step(mach_step(32'd0, 8'h20));
    add_step(run_step(1'b0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i])
      offer_beat(directed_steps[i].beat, directed_steps[i].typed, directed_steps[i].result);
    drain();

    // Random sequences: mostly load-load-run, some loose noise beats.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      send_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        njobs = $urandom_range(1, 5);
        nmach = $urandom_range(1, 4);
        repeat (njobs) begin
          p = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 50);
          d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
          send_job(p, d, $urandom);
        end
        repeat (nmach) begin
          send_machine(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100),
                       $urandom);
        end
        send_run();
        sent += njobs + nmach + 1;
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(mmda_pkg::req_t)-1:0];
        b.proc_time = $urandom_range(0, 50);
        b.due_time = $urandom_range(0, 300);
        b.avail_time = $urandom_range(0, 100);
        offer_beat(b, 1'b0, '0);
        if (b.func != FUNC_UNUSED) sent++;
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();

    // Fill both stores past their limits, then one full run.
    send_idle = 1'b1;
    repeat (JOB_SLOTS + 2) send_job($urandom_range(0, 20), $urandom, $urandom);
    repeat (MACH_SLOTS + 1) send_machine($urandom_range(0, 1000), $urandom);
    send_run();
    drain();

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Response side: random stalls, quiet stretches, and one long hold.
  initial begin
    int gap;
    rsp_ready <= 1'b0;
    recv_idle = 1'b1;
    @(negedge rst);
    forever begin
      if (rsp_beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      else begin
        if ($urandom_range(0, 31) == 0) recv_idle = ~recv_idle;
        gap = recv_idle ? $urandom_range(0, 5) : 0;
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Compare every response beat with the oldest expectation.
  always @(posedge clk) begin
    mmda_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_beats++;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response beat %p", $time, rsp);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.out_machine !== want.out_machine) begin
          errors++;
          $display("%0t: out_machine expected %h got %h", $time, want.out_machine,
                   rsp.out_machine);
        end
        if (rsp.out_job !== want.out_job) begin
          errors++;
          $display("%0t: out_job expected %h got %h", $time, want.out_job, rsp.out_job);
        end
        if (rsp.assigned !== want.assigned) begin
          errors++;
          $display("%0t: assigned expected %b got %b", $time, want.assigned, rsp.assigned);
        end
        if (rsp.last !== want.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, want.last, rsp.last);
        end
      end
    end
  end

  // Counter start values, and a watchdog on total run length.
  initial begin
    errors = 0;
    rsp_beats = 0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
